@@ hw/rtl/hrrf_pkg.sv @@
package hrrf_pkg;

  // fixed field widths
  localparam int MEAS_IN_W = 16;
  localparam int ELAPSED_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W = 16;

  // ms per second as a 10 bit constant, Q8.8 fraction bits
  localparam logic [9:0] MS_PER_S = 10'd1000;
  localparam int MS_PER_S_W = 10;
  localparam int Q_SHIFT = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd3;

  // datapath operations, one per microcode step
  typedef enum logic [2:0] {
    OP_CAPTURE,
    OP_MUL_K,
    OP_MUL_G,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH
  } dp_op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_IN,
    COND_ELAPSED_ZERO,
    COND_CNT_NZ,
    COND_OUT_BUSY
  } cond_e;

  localparam int PC_W = 3;
  localparam int STEPS = 6;
  typedef logic [PC_W-1:0] step_t;

  localparam step_t STEP_CAPTURE = 3'd0;
  localparam step_t STEP_MUL_K = 3'd1;
  localparam step_t STEP_MUL_G = 3'd2;
  localparam step_t STEP_DIV_INIT = 3'd3;
  localparam step_t STEP_DIV_STEP = 3'd4;
  localparam step_t STEP_FINISH = 3'd5;

  // one control word: operation, jump condition, jump target, wrap to step zero
  typedef struct packed {
    dp_op_e op;
    cond_e cond;
    step_t target;
    logic wrap;
  } uword_t;

  // control program
  localparam uword_t UCODE [STEPS] = '{
    '{op: OP_CAPTURE, cond: COND_NO_IN, target: STEP_CAPTURE, wrap: 1'b0},
    '{op: OP_MUL_K, cond: COND_ELAPSED_ZERO, target: STEP_FINISH, wrap: 1'b0},
    '{op: OP_MUL_G, cond: COND_NONE, target: STEP_DIV_INIT, wrap: 1'b0},
    '{op: OP_DIV_INIT, cond: COND_NONE, target: STEP_DIV_STEP, wrap: 1'b0},
    '{op: OP_DIV_STEP, cond: COND_CNT_NZ, target: STEP_DIV_STEP, wrap: 1'b0},
    '{op: OP_FINISH, cond: COND_OUT_BUSY, target: STEP_FINISH, wrap: 1'b1}
  };

  // sequencer to datapath
  typedef struct packed {
    dp_op_e op;
  } ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_valid;
    logic elapsed_zero;
    logic cnt_nz;
    logic out_busy;
  } stat_t;

endpackage

@@ hw/rtl/hrrf_if.sv @@
// input word channel
interface hrrf_in_if;
  import hrrf_pkg::*;
  logic valid;
  logic ready;
  logic [MEAS_IN_W-1:0] measurement;
  logic [ELAPSED_W-1:0] elapsed_ms;
  modport source (output valid, output measurement, output elapsed_ms, input ready);
  modport sink (input valid, input measurement, input elapsed_ms, output ready);
endinterface

// result word channel
interface hrrf_out_if;
  logic valid;
  logic ready;
  logic relay_on;
  modport source (output valid, output relay_on, input ready);
  modport sink (input valid, input relay_on, output ready);
endinterface

// configuration write channel
interface hrrf_cfg_if;
  import hrrf_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/hysteresis_relay_with_rate_feedback.sv @@
// Two-position relay with hysteresis and rate feedback. Each input word carries a
// measurement and the elapsed time in ms; the relay level after the step comes out as
// one result word. A small microcode program steps a shared datapath: a capture step,
// two multiply steps (by 1000, then by the Q8.8 gain), a divider setup step, a
// bit-serial restoring divide yielding MEAS_WIDTH+18 quotient bits (MEAS_WIDTH capped
// at 16), and a finish step that updates the relay. When elapsed_ms is zero the program
// jumps from the first multiply straight to the finish step. One item is worked on at a
// time; the next word is taken while the previous result still waits in the output
// register. Configuration writes are always ready and are meant to be issued only while
// the block is idle; writing direction reloads the relay with the inverse of the new
// polarity.
module hysteresis_relay_with_rate_feedback #(
  parameter int MEAS_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrrf_in_if.sink    in_i,
  hrrf_out_if.source out_o,
  hrrf_cfg_if.sink   cfg_i
);
  import hrrf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // control program sequencer
  hrrf_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // arithmetic and relay state
  hrrf_datapath #(
    .MEAS_WIDTH (MEAS_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

endmodule

@@ hw/rtl/hrrf_useq.sv @@
module hrrf_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hrrf_pkg::stat_t stat_i,
  output hrrf_pkg::ctrl_t ctrl_o
);
  import hrrf_pkg::*;

  step_t pc_q, pc_d;
  uword_t uw;
  logic take;

  // control store lookup
  assign uw = UCODE[pc_q];
  assign ctrl_o.op = uw.op;

  // jump condition
  always_comb begin
    unique case (uw.cond)
      COND_NONE:         take = 1'b0;
      COND_NO_IN:        take = !stat_i.in_valid;
      COND_ELAPSED_ZERO: take = stat_i.elapsed_zero;
      COND_CNT_NZ:       take = stat_i.cnt_nz;
      COND_OUT_BUSY:     take = stat_i.out_busy;
      default:           take = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (take) begin
      pc_d = uw.target;
    end else if (uw.wrap) begin
      pc_d = STEP_CAPTURE;
    end else begin
      pc_d = pc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_CAPTURE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

@@ hw/rtl/hrrf_datapath.sv @@
module hrrf_datapath #(
  parameter int MEAS_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  hrrf_in_if.sink         in_i,
  hrrf_out_if.source      out_o,
  hrrf_cfg_if.sink        cfg_i,
  input  hrrf_pkg::ctrl_t ctrl_i,
  output hrrf_pkg::stat_t stat_o
);
  import hrrf_pkg::*;

  // effective measurement width, product, quotient and signal widths
  localparam int EW = (MEAS_WIDTH < MEAS_IN_W) ? MEAS_WIDTH : MEAS_IN_W;
  localparam int KW = EW + MS_PER_S_W;
  localparam int NW = KW + GAIN_W;
  localparam int QN = NW - Q_SHIFT;
  localparam int SW = QN + 2;
  localparam int CW = $clog2(QN);

  // configuration registers
  logic [CFG_DATA_W-1:0] setpoint_q, hyst_q;
  logic [GAIN_W-1:0] gain_q;
  logic dir_q;

  // state
  logic [EW-1:0] prev_q;
  logic relay_q;
  logic out_valid_q;

  // working registers
  logic [EW-1:0] meas_q;
  logic [ELAPSED_W-1:0] elapsed_q;
  logic neg_q;
  logic [NW-1:0] acc_q;
  logic [ELAPSED_W-1:0] rem_q;
  logic [CW-1:0] cnt_q;

  logic capture, commit, elapsed_zero;
  logic [EW-1:0] meas_in;
  logic [EW:0] diff;
  logic [EW-1:0] diff_mag;
  logic [GAIN_W-1:0] gain_mag;
  logic [KW-1:0] prod_k;
  logic [NW-1:0] prod_g;
  logic [ELAPSED_W:0] r2;
  logic ge;
  logic [SW-1:0] tmag, term, signal_u, hi_u, lo_u;
  logic above, below;

  assign in_i.ready = (ctrl_i.op == OP_CAPTURE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.relay_on = relay_q;

  assign capture = (ctrl_i.op == OP_CAPTURE) && in_i.valid;
  assign elapsed_zero = (elapsed_q == '0);

  assign stat_o.in_valid = in_i.valid;
  assign stat_o.elapsed_zero = elapsed_zero;
  assign stat_o.cnt_nz = (cnt_q != '0);
  assign stat_o.out_busy = out_valid_q && !out_o.ready;
  assign commit = (ctrl_i.op == OP_FINISH) && !stat_o.out_busy;

  // difference to previous sample as sign and magnitude
  assign meas_in = in_i.measurement[EW-1:0];
  assign diff = {1'b0, meas_in} - {1'b0, prev_q};
  assign diff_mag = diff[EW] ? EW'(~diff + 1'b1) : diff[EW-1:0];

  // multiplier operands
  assign gain_mag = gain_q[GAIN_W-1] ? (~gain_q + GAIN_W'(1)) : gain_q;
  assign prod_k = KW'(acc_q[EW-1:0]) * KW'(MS_PER_S);
  assign prod_g = NW'(acc_q[KW-1:0]) * NW'(gain_mag);

  // one restoring divide step
  assign r2 = {rem_q, acc_q[QN-1]};
  assign ge = (r2 >= {1'b0, elapsed_q});

  // anticipated signal against the dead band
  assign tmag = elapsed_zero ? '0 : SW'(acc_q[QN-1:0]);
  assign term = neg_q ? (~tmag + SW'(1)) : tmag;
  assign signal_u = SW'(meas_q) + term;
  assign hi_u = SW'(setpoint_q) + SW'(hyst_q[CFG_DATA_W-1:1]);
  assign lo_u = SW'(setpoint_q) - SW'(hyst_q[CFG_DATA_W-1:1]);
  assign above = $signed(signal_u) > $signed(hi_u);
  assign below = $signed(signal_u) < $signed(lo_u);

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      OP_CAPTURE: begin
        if (capture) begin
          meas_q <= meas_in;
          elapsed_q <= in_i.elapsed_ms;
          neg_q <= diff[EW];
          acc_q <= NW'(diff_mag);
        end
      end
      OP_MUL_K: begin
        acc_q <= NW'(prod_k);
      end
      OP_MUL_G: begin
        acc_q <= prod_g;
        neg_q <= neg_q ^ gain_q[GAIN_W-1];
      end
      OP_DIV_INIT: begin
        acc_q <= acc_q >> Q_SHIFT;
        rem_q <= '0;
        cnt_q <= CW'(QN - 1);
      end
      OP_DIV_STEP: begin
        rem_q <= ge ? ELAPSED_W'(r2 - {1'b0, elapsed_q}) : r2[ELAPSED_W-1:0];
        acc_q <= NW'({acc_q[QN-2:0], ge});
        cnt_q <= cnt_q - CW'(1);
      end
      OP_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // configuration, relay level and previous sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      hyst_q <= '0;
      gain_q <= '0;
      dir_q <= 1'b0;
      prev_q <= '0;
      relay_q <= 1'b1;
    end else begin
      if (commit) begin
        if (!elapsed_zero) begin
          prev_q <= meas_q;
        end
        if (above) begin
          relay_q <= ~dir_q;
        end else if (below) begin
          relay_q <= dir_q;
        end
      end
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_SETPOINT:   setpoint_q <= cfg_i.data;
          CFG_HYSTERESIS: hyst_q <= cfg_i.data;
          CFG_RATE_GAIN:  gain_q <= cfg_i.data;
          CFG_DIRECTION: begin
            dir_q <= cfg_i.data[0];
            relay_q <= ~cfg_i.data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/hrrf_checker.sv @@
module hrrf_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             out_relay_on_i,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_i,
  input logic [hrrf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input logic [hrrf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import hrrf_pkg::*;

  // a pending result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped before taken");

  // a stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_relay_on_i))
    else $error("stalled result word changed");

  // one word in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a word is being worked");

  // writing polarity reloads the relay with its inverse
  a_dir_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_i && (cfg_index_i == CFG_DIRECTION)
      |=> out_relay_on_i == !$past(cfg_data_i[0]))
    else $error("relay not reloaded on polarity write");

endmodule

bind hysteresis_relay_with_rate_feedback hrrf_checker u_hrrf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_relay_on_i (out_o.relay_on),
  .cfg_valid_i    (cfg_i.valid),
  .cfg_ready_i    (cfg_i.ready),
  .cfg_index_i    (cfg_i.index),
  .cfg_data_i     (cfg_i.data)
);

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // settle time for a word with a rate term at the default width, plus the output register
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 100;
  localparam int unsigned MAX_SHOWN = 25;

  // register indexes past the last register, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  localparam longint MS_PER_SEC = 1000;
  localparam longint Q88_ONE = 256;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  // one directed row: a data word (a = measurement, b = elapsed) or a register write (a = data)
  typedef struct packed {
    row_kind_e kind;
    logic typed;
    logic relay;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0] a;
    logic [15:0] b;
  } row_t;

  localparam int unsigned NUM_ROWS = 34;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // straight after reset the relay sits high and zero equals the setpoint
    '{ROW_WORD, 1'b1, 1'b1, '0, 16'd0, 16'd0},
    '{ROW_WORD, 1'b1, 1'b1, '0, 16'd1, 16'd0},
    // band 900..1100, both edges hold
    '{ROW_REG, 1'b0, 1'b0, CFG_SETPOINT, 16'd1000, 16'd0},
    '{ROW_REG, 1'b0, 1'b0, CFG_HYSTERESIS, 16'd200, 16'd0},
    '{ROW_WORD, 1'b1, 1'b0, '0, 16'd0, 16'd0},
    '{ROW_WORD, 1'b1, 1'b0, '0, 16'd1100, 16'd0},
    '{ROW_WORD, 1'b1, 1'b1, '0, 16'd1101, 16'd0},
    '{ROW_WORD, 1'b1, 1'b1, '0, 16'd900, 16'd0},
    '{ROW_WORD, 1'b1, 1'b0, '0, 16'd899, 16'd0},
    // flipped polarity reloads the relay low
    '{ROW_REG, 1'b0, 1'b0, CFG_DIRECTION, 16'hFFFF, 16'd0},
    '{ROW_WORD, 1'b1, 1'b0, '0, 16'd1000, 16'd0},
    '{ROW_WORD, 1'b1, 1'b0, '0, 16'hFFFF, 16'd0},
    '{ROW_WORD, 1'b1, 1'b1, '0, 16'd0, 16'd0},
    // write to an unused index is dropped
    '{ROW_REG, 1'b0, 1'b0, CFG_UNUSED_LO, 16'hFFFF, 16'd0},
    '{ROW_WORD, 1'b1, 1'b1, '0, 16'd1000, 16'd0},
    // largest positive gain, then the most negative one
    '{ROW_REG, 1'b0, 1'b0, CFG_RATE_GAIN, 16'h7FFF, 16'd0},
    '{ROW_WORD, 1'b0, 1'b0, '0, 16'd0, 16'd1},
    '{ROW_WORD, 1'b0, 1'b0, '0, 16'hFFFF, 16'd1},
    '{ROW_WORD, 1'b0, 1'b0, '0, 16'd0, 16'hFFFF},
    '{ROW_REG, 1'b0, 1'b0, CFG_RATE_GAIN, 16'h8000, 16'd0},
    '{ROW_WORD, 1'b0, 1'b0, '0, 16'hFFFF, 16'hFFFF},
    // zero elapsed time leaves the stored measurement alone
    '{ROW_WORD, 1'b0, 1'b0, '0, 16'd1000, 16'd0},
    '{ROW_WORD, 1'b0, 1'b0, '0, 16'd0, 16'hFFFF},
    // unity gain, no dead band, setpoint at the top
    '{ROW_REG, 1'b0, 1'b0, CFG_RATE_GAIN, 16'h0100, 16'd0},
    '{ROW_REG, 1'b0, 1'b0, CFG_HYSTERESIS, 16'd0, 16'd0},
    '{ROW_REG, 1'b0, 1'b0, CFG_SETPOINT, 16'hFFFF, 16'd0},
    '{ROW_WORD, 1'b0, 1'b0, '0, 16'hFFFF, 16'd3},
    // only bit zero of the polarity data counts
    '{ROW_REG, 1'b0, 1'b0, CFG_DIRECTION, 16'h0002, 16'd0},
    '{ROW_WORD, 1'b1, 1'b1, '0, 16'hFFFF, 16'd0},
    // small negative rate truncates toward zero
    '{ROW_WORD, 1'b0, 1'b0, '0, 16'hFFFE, 16'd7},
    // widest band around zero
    '{ROW_REG, 1'b0, 1'b0, CFG_HYSTERESIS, 16'hFFFF, 16'd0},
    '{ROW_REG, 1'b0, 1'b0, CFG_SETPOINT, 16'd0, 16'd0},
    '{ROW_WORD, 1'b1, 1'b0, '0, 16'd32767, 16'd0},
    '{ROW_WORD, 1'b1, 1'b1, '0, 16'd32768, 16'd0}
  };

  logic clk_i;
  logic rst_ni;

  hrrf_in_if in_if ();
  hrrf_out_if out_if ();
  hrrf_cfg_if cfg_if ();

  hysteresis_relay_with_rate_feedback dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // predictor copy of the registers and state
  logic [15:0] reg_setpoint;
  logic [15:0] reg_hyst;
  logic signed [15:0] reg_gain;
  logic reg_dir;
  logic [15:0] pred_prev_meas;
  logic pred_relay;

  logic expected_relay[$];

  bit calm;
  logic [15:0] last_meas;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned rate_words;
  int unsigned reg_writes;
  int unsigned results_seen;
  int unsigned toggles;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("hysteresis_relay_with_rate_feedback: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%0t ns: %s", $time, what);
  endtask

  // register write as the block sees it
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [15:0] data);
    case (idx)
      CFG_SETPOINT: reg_setpoint = data;
      CFG_HYSTERESIS: reg_hyst = data;
      CFG_RATE_GAIN: reg_gain = data;
      CFG_DIRECTION: begin
        reg_dir = data[0];
        pred_relay = ~data[0];
      end
      default: ;
    endcase
  endfunction

  // anticipated signal against the dead band, returns the relay level after the step
  function automatic logic relay_after_step(input logic [15:0] meas, input logic [15:0] el);
    longint signal;
    longint half;
    longint lead;
    signal = longint'(meas);
    half = longint'(reg_hyst >> 1);
    if (el != 16'd0) begin
      lead = (longint'(meas) - longint'(pred_prev_meas)) * MS_PER_SEC * longint'(reg_gain)
             / (longint'(el) * Q88_ONE);
      signal = signal + lead;
      pred_prev_meas = meas;
    end
    if (signal > longint'(reg_setpoint) + half) pred_relay = ~reg_dir;
    else if (signal < longint'(reg_setpoint) - half) pred_relay = reg_dir;
    return pred_relay;
  endfunction

  // drop valid and wait until every predicted word is back and the block has settled
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (expected_relay.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    quiesce();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    apply_reg_write(idx, data);
    reg_writes++;
  endtask

  // valid stays high across back-to-back words, dropped only for a gap
  task automatic send_word(input logic [15:0] meas, input logic [15:0] el,
                           input logic typed, input logic typed_relay);
    int unsigned gap;
    logic predicted;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.measurement <= meas;
    in_if.elapsed_ms <= el;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    predicted = relay_after_step(meas, el);
    expected_relay.push_back(typed ? typed_relay : predicted);
    last_meas = meas;
    words_sent++;
    if (el != 16'd0) rate_words++;
  endtask

  // result side: random backpressure and the comparison
  initial begin : result_side
    int unsigned ready_hold;
    logic want;
    logic prev_relay;
    ready_hold = 0;
    prev_relay = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_if.valid && out_if.ready) begin
          results_seen++;
          if (expected_relay.size() == 0) begin
            report_mismatch($sformatf("relay word %0d arrived with none pending",
                                      results_seen));
          end else begin
            want = expected_relay.pop_front();
            if (out_if.relay_on !== want)
              report_mismatch($sformatf("relay word %0d: relay_on %b, predicted %b",
                                        results_seen, out_if.relay_on, want));
          end
          if (results_seen > 1 && out_if.relay_on != prev_relay) toggles++;
          prev_relay = out_if.relay_on;
          ready_hold = calm ? 0 : $urandom_range(0, 7);
        end
        if (ready_hold > 0) begin
          out_if.ready <= 1'b0;
          ready_hold--;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int span;
    int v;
    logic [15:0] meas;
    logic [15:0] el;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.measurement = '0;
    in_if.elapsed_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_SETPOINT;
    cfg_if.data = '0;
    calm = 1'b0;
    last_meas = '0;
    mismatches = 0;
    words_sent = 0;
    rate_words = 0;
    reg_writes = 0;
    results_seen = 0;
    toggles = 0;
    reg_setpoint = '0;
    reg_hyst = '0;
    reg_gain = '0;
    reg_dir = 1'b0;
    pred_prev_meas = '0;
    pred_relay = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_REG) write_reg(DIRECTED[r].idx, DIRECTED[r].a);
      else send_word(DIRECTED[r].a, DIRECTED[r].b, DIRECTED[r].typed, DIRECTED[r].relay);
    end

    // random phases, each under its own settings
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      calm = (phase % 3 == 2);
      case (phase)
        0: begin
          write_reg(CFG_SETPOINT, 16'd0);
          write_reg(CFG_HYSTERESIS, 16'd0);
        end
        1: begin
          write_reg(CFG_SETPOINT, 16'hFFFF);
          write_reg(CFG_HYSTERESIS, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_SETPOINT, 16'($urandom));
          write_reg(CFG_HYSTERESIS, $urandom_range(0, 3) == 0 ? 16'($urandom)
                                                             : 16'($urandom_range(0, 4000)));
        end
      endcase
      case (phase)
        2: write_reg(CFG_RATE_GAIN, 16'h7FFF);
        3: write_reg(CFG_RATE_GAIN, 16'h8000);
        default: write_reg(CFG_RATE_GAIN, $urandom_range(0, 1) ? 16'($urandom)
                                                              : 16'($urandom_range(0, 1024) - 512));
      endcase
      write_reg(CFG_DIRECTION, 16'($urandom));
      if ($urandom_range(0, 1))
        write_reg(3'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), 16'($urandom));

      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // hold off once mid-phase until the result side has caught up
        if (i == WORDS_PER_PHASE / 2) quiesce();
        // measurement: full range, around the band, or close to the last one
        case ($urandom_range(0, 3))
          0: v = int'($urandom_range(0, 65535));
          1, 2: begin
            span = int'(reg_hyst >> 1) + 64;
            v = int'(reg_setpoint) + int'($urandom_range(0, 2 * span)) - span;
          end
          default: v = int'(last_meas) + int'($urandom_range(0, 128)) - 64;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        meas = 16'(v);
        // elapsed time: none, short, moderate or anything
        case ($urandom_range(0, 3))
          0: el = 16'd0;
          1: el = 16'($urandom_range(1, 16));
          2: el = 16'($urandom_range(17, 2000));
          default: el = 16'($urandom);
        endcase
        send_word(meas, el, 1'b0, 1'b0);
      end
    end

    calm = 1'b0;
    quiesce();
    $display("covered %0d words (%0d with a rate term) and %0d register writes",
             words_sent, rate_words, reg_writes);
    $display("checked %0d relay words, %0d level changes, %0d mismatches",
             results_seen, toggles, mismatches);
    if (mismatches == 0) begin
      $display("hysteresis_relay_with_rate_feedback: match");
    end else begin
      $display("hysteresis_relay_with_rate_feedback: mismatch");
    end
    $finish;
  end

endmodule
